// ===== rtl/hashed_slot_allocator_macros.svh =====
// Assertion macros shared by the slot allocator RTL.
// Depends on nothing; the asserting module supplies i_clk and i_rst_n.
`ifndef HASHED_SLOT_ALLOCATOR_MACROS_SVH
`define HASHED_SLOT_ALLOCATOR_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define HSA_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define HSA_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/hsa_pkg.sv =====
// Constants and helpers for the hashed slot allocator.
// Depends on nothing; used by hashed_slot_allocator.
package hsa_pkg;

    localparam int KIND_W    = 2;
    localparam int SLOT_W    = 8;
    localparam int NUM_SLOTS = 255;

    localparam logic [KIND_W-1:0] KIND_CHAR  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_END   = 2'd1;
    localparam logic [KIND_W-1:0] KIND_CLEAR = 2'd2;

    localparam logic [SLOT_W-1:0] HASH_MUL  = 8'd19;
    localparam logic [SLOT_W-1:0] HASH_ADD  = 8'd13;
    localparam logic [SLOT_W-1:0] LAST_SLOT = 8'(NUM_SLOTS);
    localparam logic [SLOT_W-1:0] LAST_ADDR = 8'(NUM_SLOTS - 1);

    // Linear probe order: 1, 2, ..., 255, then back to 1.
    function automatic logic [SLOT_W-1:0] next_slot(input logic [SLOT_W-1:0] s);
        logic [SLOT_W-1:0] r;
        r = (s >= LAST_SLOT) ? 8'd1 : s + 8'd1;
        return r;
    endfunction

endpackage

// ===== rtl/hashed_slot_allocator.sv =====
// An end item raises o_valid once its probe has checked N slots (1..255), one map read
// per cycle. Throughput: one character item per cycle while idle; an end item holds the
// input for the probe.
// A clear item, and reset, sweep the 255-entry occupancy memory one entry per cycle,
// so the block takes no item until the sweep ends.
// Reset is synchronous, active low; the hash returns to zero and the output is empty.
`include "hashed_slot_allocator_macros.svh"

module hashed_slot_allocator
    import hsa_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_stall,
    input  logic [KIND_W-1:0] i_kind,
    input  logic [SLOT_W-1:0] i_ch,
    output logic              o_valid,
    input  logic              i_stall,
    output logic [SLOT_W-1:0] o_slot,
    output logic              o_full_res
);

    // Control states. The clear sweep is also where reset lands, since the
    // occupancy memory itself has no reset.
    localparam logic [1:0] ST_CLEAR = 2'd0;
    localparam logic [1:0] ST_IDLE  = 2'd1;
    localparam logic [1:0] ST_PROBE = 2'd2;

    logic [1:0]        r_state,    n_state;
    logic [SLOT_W-1:0] r_hash,     n_hash;
    logic [SLOT_W-1:0] r_clr,      n_clr;
    logic [SLOT_W-1:0] r_rd_slot,  n_rd_slot;
    logic [SLOT_W-1:0] r_chk_slot, n_chk_slot;
    logic              r_chk_vld,  n_chk_vld;
    logic [SLOT_W-1:0] r_count,    n_count;
    logic              r_out_vld,  n_out_vld;
    logic [SLOT_W-1:0] r_slot,     n_slot;
    logic              r_full,     n_full;

    // Occupancy map: entry a holds the taken flag of slot a+1.
    logic              r_mem [0:NUM_SLOTS-1];
    logic              r_rd_data;
    logic [SLOT_W-1:0] rd_addr;
    logic              wr_en;
    logic [SLOT_W-1:0] wr_addr;
    logic              wr_data;

    logic              in_accept;
    logic [SLOT_W-1:0] ch_term;
    logic [SLOT_W-1:0] start_slot;

    // An end item is held off while a previous result still waits, so the
    // probe can always finish into an empty output register.
    assign o_stall   = (r_state != ST_IDLE) || (r_out_vld && (i_kind == KIND_END));
    assign in_accept = i_valid && !o_stall;

    assign o_valid    = r_out_vld;
    assign o_slot     = r_slot;
    assign o_full_res = r_full;

    // Character contribution (ch*19) mod 256; the +13 is added with the hash.
    assign ch_term    = 8'(16'(i_ch) * 16'(HASH_MUL));
    assign start_slot = (r_hash == 8'd0) ? 8'd1 : r_hash;
    assign rd_addr    = r_rd_slot - 8'd1;

    // The probe issues one read per cycle. The read of slot s returns in the
    // next cycle while slot s+1 is already being read, so r_chk_slot tracks
    // which slot r_rd_data belongs to. The first free slot ends the probe;
    // the read issued alongside it is simply dropped. The only write in a
    // probe happens as it ends, so no read can see a stale entry.
    always_comb begin
        n_state    = r_state;
        n_hash     = r_hash;
        n_clr      = r_clr;
        n_rd_slot  = r_rd_slot;
        n_chk_slot = r_chk_slot;
        n_chk_vld  = r_chk_vld;
        n_count    = r_count;
        n_out_vld  = r_out_vld;
        n_slot     = r_slot;
        n_full     = r_full;
        wr_en      = 1'b0;
        wr_addr    = r_clr;
        wr_data    = 1'b0;

        if (r_out_vld && !i_stall) begin
            n_out_vld = 1'b0;
        end

        unique case (r_state)
            ST_CLEAR: begin
                wr_en   = 1'b1;
                wr_addr = r_clr;
                wr_data = 1'b0;
                n_clr   = r_clr + 8'd1;
                if (r_clr == LAST_ADDR) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (in_accept) begin
                    case (i_kind)
                        KIND_CHAR: begin
                            n_hash = r_hash + ch_term + HASH_ADD;
                        end
                        KIND_END: begin
                            n_rd_slot = start_slot;
                            n_hash    = 8'd0;
                            n_chk_vld = 1'b0;
                            n_count   = 8'd0;
                            n_state   = ST_PROBE;
                        end
                        KIND_CLEAR: begin
                            n_clr   = 8'd0;
                            n_state = ST_CLEAR;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_PROBE: begin
                n_chk_slot = r_rd_slot;
                n_chk_vld  = 1'b1;
                n_rd_slot  = next_slot(r_rd_slot);
                if (r_chk_vld) begin
                    if (!r_rd_data) begin
                        wr_en     = 1'b1;
                        wr_addr   = r_chk_slot - 8'd1;
                        wr_data   = 1'b1;
                        n_out_vld = 1'b1;
                        n_slot    = r_chk_slot;
                        n_full    = 1'b0;
                        n_state   = ST_IDLE;
                    end else if (r_count == LAST_ADDR) begin
                        // Every slot has been seen taken: the map is full.
                        n_out_vld = 1'b1;
                        n_slot    = 8'd0;
                        n_full    = 1'b1;
                        n_state   = ST_IDLE;
                    end else begin
                        n_count = r_count + 8'd1;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        if (r_state == ST_PROBE) begin
            r_rd_data <= r_mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_CLEAR;
            r_hash    <= 8'd0;
            r_clr     <= 8'd0;
            r_chk_vld <= 1'b0;
            r_count   <= 8'd0;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_hash    <= n_hash;
            r_clr     <= n_clr;
            r_chk_vld <= n_chk_vld;
            r_count   <= n_count;
            r_out_vld <= n_out_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_slot  <= n_rd_slot;
        r_chk_slot <= n_chk_slot;
        r_slot     <= n_slot;
        r_full     <= n_full;
    end

    `HSA_ASSERT_NOW(a_full_is_slot_zero, o_valid, (o_full_res == (o_slot == 8'd0)), "full flag and slot disagree")
    `HSA_ASSERT_NOW(a_alloc_only_free, (r_state == ST_PROBE) && wr_en, (r_chk_vld && !r_rd_data), "probe wrote a slot not seen free")
    `HSA_ASSERT_NEXT(a_end_starts_probe, in_accept && (i_kind == KIND_END), (r_state == ST_PROBE) && !r_chk_vld, "end item did not start a probe")
    `HSA_ASSERT_NOW(a_busy_stalls, (r_state != ST_IDLE), o_stall, "input taken while busy")

endmodule
